>>> hw/rtl/lspb_pkg.sv
package lspb_pkg;

	localparam int unsigned ACTION_W    = 3;
	localparam int unsigned INDEX_W     = 8;
	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned WORD_W      = 24;
	localparam int unsigned ACTIVE_W    = 7;
	localparam int unsigned GAIN_W      = 8;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned PROD_W      = 2 * CHAN_W;

	typedef logic [INDEX_W-1:0]     index_t;
	typedef logic [CHAN_W-1:0]      chan_t;
	typedef logic [WORD_W-1:0]      word_t;
	typedef logic [ACTIVE_W-1:0]    active_t;
	typedef logic [GAIN_W-1:0]      gain_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [PROD_W-1:0]      prod_t;

	localparam cfg_index_t REG_ACTIVE_PIXELS   = 1'b0;
	localparam cfg_index_t REG_BRIGHTNESS_GAIN = 1'b1;

	localparam active_t ACTIVE_RESET = 7'd64;
	localparam gain_t   GAIN_RESET   = 8'd255;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SET_ONE   = 3'd0,
		ACT_SET_ALL   = 3'd1,
		ACT_ROT_RIGHT = 3'd2,
		ACT_ROT_LEFT  = 3'd3,
		ACT_SEND      = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FILL,
		BK_SEND,
		BK_COPY_OUT,
		BK_COPY_BACK
	} back_state_t;

	typedef struct packed {
		action_t op;
		index_t  index;
		word_t   color;
	} cmd_t;

	typedef struct packed {
		logic  valid;
		logic  last;
		word_t grb;
	} pix_t;

	// floor(x / 255) for x up to 255 * 255
	function automatic chan_t div255(input prod_t x);
		prod_t sum;
		sum = x + prod_t'(x >> CHAN_W) + prod_t'(1);
		return sum[PROD_W-1:CHAN_W];
	endfunction

endpackage

>>> hw/rtl/lspb_front.sv
module lspb_front #(
	parameter int unsigned MAX_PIXELS = 64
) (
	input  logic                             start,
	input  logic [lspb_pkg::ACTION_W-1:0]    action,
	input  lspb_pkg::index_t                 pixel_index,
	input  lspb_pkg::chan_t                  red,
	input  lspb_pkg::chan_t                  green,
	input  lspb_pkg::chan_t                  blue,
	input  logic [$clog2(MAX_PIXELS+1)-1:0]  pixel_count,
	input  logic                             q_full,
	output logic                             busy,
	output logic                             push,
	output lspb_pkg::cmd_t                   cmd
);

	logic keep;
	logic accept;

	// drop requests that cannot change anything
	always_comb begin
		keep = 1'b0;
		unique case (action)
			lspb_pkg::ACT_SET_ONE: begin
				keep = pixel_index < lspb_pkg::index_t'(pixel_count);
			end
			lspb_pkg::ACT_SET_ALL,
			lspb_pkg::ACT_ROT_RIGHT,
			lspb_pkg::ACT_ROT_LEFT,
			lspb_pkg::ACT_SEND: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		if (pixel_count == '0) begin
			keep = 1'b0;
		end
	end

	assign accept    = start && !q_full;
	assign busy      = q_full;
	assign push      = accept && keep;
	assign cmd.op    = lspb_pkg::action_t'(action);
	assign cmd.index = pixel_index;
	assign cmd.color = {green, red, blue};

endmodule

>>> hw/rtl/lspb_cmd_queue.sv
module lspb_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lspb_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output lspb_pkg::cmd_t head
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = 1;
	localparam int unsigned CNT_W = 2;

	lspb_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> hw/rtl/lspb_back.sv
module lspb_back #(
	parameter int unsigned MAX_PIXELS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(MAX_PIXELS+1)-1:0]  pixel_count,
	input  logic                             renorm,
	input  logic                             q_valid,
	input  lspb_pkg::cmd_t                   q_head,
	output logic                             q_pop,
	output lspb_pkg::pix_t                   pix
);

	localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
	localparam int unsigned SW = AW + 1;

	typedef logic [AW-1:0] addr_t;
	typedef logic [SW-1:0] sum_t;
	typedef logic [CW-1:0] count_t;

	// (a + b) mod n with a, b below n
	function automatic addr_t wrap_add(input addr_t a, input addr_t b, input count_t n);
		sum_t s;
		sum_t lim;
		s   = sum_t'(a) + sum_t'(b);
		lim = sum_t'(n);
		if (s >= lim) begin
			s = s - lim;
		end
		return s[AW-1:0];
	endfunction

	lspb_pkg::back_state_t state_q;
	lspb_pkg::back_state_t state_d;
	addr_t                 cnt_q;
	addr_t                 base_q;
	addr_t                 base_d;
	count_t                job_count_q;
	addr_t                 job_base_q;
	lspb_pkg::word_t       fill_color_q;
	logic [MAX_PIXELS-1:0] valid_q;

	lspb_pkg::word_t store_mem [MAX_PIXELS];
	lspb_pkg::word_t tmp_mem [MAX_PIXELS];

	logic            send_s1;
	logic            last_s1;
	logic            copy_s1;
	logic            back_s1;
	addr_t           idx_s1;
	lspb_pkg::word_t rd_data_s1;
	logic            rd_valid_s1;
	lspb_pkg::word_t tmp_data_s1;

	addr_t           last_addr;
	addr_t           job_last_addr;
	logic            cnt_last;
	logic            job_last;
	logic            st_we;
	addr_t           st_waddr;
	lspb_pkg::word_t st_wdata;
	addr_t           rd_addr;
	logic            issue_send;
	logic            issue_copy;
	logic            issue_back;
	logic            job_load;
	logic            fill_load;

	assign last_addr     = addr_t'(pixel_count - 1'b1);
	assign job_last_addr = addr_t'(job_count_q - 1'b1);
	assign cnt_last      = (cnt_q == last_addr);
	assign job_last      = (cnt_q == job_last_addr);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lspb_pkg::BK_IDLE: begin
				if (renorm) begin
					if (base_q != '0) begin
						state_d = lspb_pkg::BK_COPY_OUT;
					end
				end else if (q_valid && !back_s1) begin
					if (q_head.op == lspb_pkg::ACT_SET_ALL) begin
						state_d = lspb_pkg::BK_FILL;
					end else if (q_head.op == lspb_pkg::ACT_SEND) begin
						state_d = lspb_pkg::BK_SEND;
					end
				end
			end
			lspb_pkg::BK_FILL, lspb_pkg::BK_SEND: begin
				if (cnt_last) begin
					state_d = lspb_pkg::BK_IDLE;
				end
			end
			lspb_pkg::BK_COPY_OUT: begin
				if (job_last) begin
					state_d = lspb_pkg::BK_COPY_BACK;
				end
			end
			lspb_pkg::BK_COPY_BACK: begin
				if (job_last) begin
					state_d = lspb_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lspb_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		st_we      = 1'b0;
		st_waddr   = cnt_q;
		st_wdata   = fill_color_q;
		rd_addr    = wrap_add(base_q, cnt_q, pixel_count);
		issue_send = 1'b0;
		issue_copy = 1'b0;
		issue_back = 1'b0;
		base_d     = base_q;
		job_load   = 1'b0;
		fill_load  = 1'b0;
		// write-back half of the copy owns the store write port
		if (back_s1) begin
			st_we    = 1'b1;
			st_waddr = idx_s1;
			st_wdata = tmp_data_s1;
		end
		unique case (state_q)
			lspb_pkg::BK_IDLE: begin
				if (renorm) begin
					base_d   = '0;
					job_load = 1'b1;
				end else if (q_valid && !back_s1) begin
					q_pop = 1'b1;
					unique case (q_head.op)
						lspb_pkg::ACT_SET_ONE: begin
							st_we    = 1'b1;
							st_waddr = wrap_add(base_q, q_head.index[AW-1:0], pixel_count);
							st_wdata = q_head.color;
						end
						lspb_pkg::ACT_SET_ALL: begin
							fill_load = 1'b1;
						end
						lspb_pkg::ACT_ROT_RIGHT: begin
							base_d = (base_q == '0) ? last_addr : base_q - 1'b1;
						end
						lspb_pkg::ACT_ROT_LEFT: begin
							base_d = (base_q == last_addr) ? '0 : base_q + 1'b1;
						end
						default: begin
							base_d = base_q;
						end
					endcase
				end
			end
			lspb_pkg::BK_FILL: begin
				st_we = 1'b1;
			end
			lspb_pkg::BK_SEND: begin
				issue_send = 1'b1;
			end
			lspb_pkg::BK_COPY_OUT: begin
				issue_copy = 1'b1;
				rd_addr    = wrap_add(job_base_q, cnt_q, job_count_q);
			end
			lspb_pkg::BK_COPY_BACK: begin
				issue_back = 1'b1;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lspb_pkg::BK_IDLE;
			cnt_q       <= '0;
			base_q      <= '0;
			job_count_q <= '0;
			job_base_q  <= '0;
			valid_q     <= '0;
			send_s1     <= 1'b0;
			last_s1     <= 1'b0;
			copy_s1     <= 1'b0;
			back_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d == state_q && state_q != lspb_pkg::BK_IDLE) ? cnt_q + 1'b1 : '0;
			base_q  <= base_d;
			if (job_load) begin
				job_count_q <= pixel_count;
				job_base_q  <= base_q;
			end
			if (st_we) begin
				valid_q[st_waddr] <= 1'b1;
			end
			send_s1 <= issue_send;
			last_s1 <= issue_send && cnt_last;
			copy_s1 <= issue_copy;
			back_s1 <= issue_back;
		end
	end

	always_ff @(posedge clk) begin
		if (fill_load) begin
			fill_color_q <= q_head.color;
		end
		idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= st_wdata;
		end
		rd_data_s1  <= store_mem[rd_addr];
		rd_valid_s1 <= valid_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (copy_s1) begin
			tmp_mem[idx_s1] <= rd_valid_s1 ? rd_data_s1 : '0;
		end
		tmp_data_s1 <= tmp_mem[cnt_q];
	end

	assign pix.valid = send_s1;
	assign pix.last  = last_s1;
	assign pix.grb   = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

>>> hw/rtl/lspb_scale.sv
module lspb_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  lspb_pkg::gain_t   gain,
	input  lspb_pkg::pix_t    pix,
	output logic              strobe,
	output lspb_pkg::word_t   grb_word,
	output logic              last
);

	localparam int unsigned CW = lspb_pkg::CHAN_W;

	logic             valid_s2;
	logic             last_s2;
	lspb_pkg::prod_t  prod_g_s2;
	lspb_pkg::prod_t  prod_r_s2;
	lspb_pkg::prod_t  prod_b_s2;
	logic             strobe_s3;
	logic             last_s3;
	lspb_pkg::word_t  word_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			last_s2   <= 1'b0;
			strobe_s3 <= 1'b0;
			last_s3   <= 1'b0;
		end else begin
			valid_s2  <= pix.valid;
			last_s2   <= pix.valid && pix.last;
			strobe_s3 <= valid_s2;
			last_s3   <= valid_s2 && last_s2;
		end
	end

	// one 8x8 product per channel, then the divide-by-255 correction
	always_ff @(posedge clk) begin
		prod_g_s2 <= lspb_pkg::prod_t'(pix.grb[3*CW-1:2*CW]) * lspb_pkg::prod_t'(gain);
		prod_r_s2 <= lspb_pkg::prod_t'(pix.grb[2*CW-1:CW]) * lspb_pkg::prod_t'(gain);
		prod_b_s2 <= lspb_pkg::prod_t'(pix.grb[CW-1:0]) * lspb_pkg::prod_t'(gain);
		word_s3   <= {lspb_pkg::div255(prod_g_s2), lspb_pkg::div255(prod_r_s2),
			lspb_pkg::div255(prod_b_s2)};
	end

	assign strobe   = strobe_s3;
	assign grb_word = word_s3;
	assign last     = last_s3;

endmodule

>>> hw/rtl/led_strip_pixel_buffer.sv
// Pixel buffer for an addressable RGB LED strip of up to MAX_PIXELS pixels. Commands arrive
// on start while busy is low: set one pixel, set all active pixels, rotate the active pixels
// right or left by one place, or send a frame. A send emits one green-red-blue word per active
// pixel on grb_word with strobe high for one cycle each, the words of one frame on consecutive
// cycles and last high on the final word; the receiver cannot stall them, so it must take a
// word every cycle. Each channel is scaled by brightness_gain / 255, rounded down. Requests
// pass through a two-entry queue into an executor that owns the pixel memory (one write and
// one read port), so busy rises only when two requests are waiting. A set-all or a send walks
// the N active pixels in turn, and frame words pass the memory read register and the scaling
// registers on the way out. Writing active_pixels while the strip is rotated triggers a
// reorder pass that copies the N pixels (N the old count) out to a scratch memory and back,
// during which new requests queue up. The pixel memory reads as all zeros after reset.
// Configuration is written through cfg_we / cfg_index / cfg_data: index 0 is active_pixels
// (values above MAX_PIXELS act as MAX_PIXELS, zero disables the strip), index 1 is
// brightness_gain; write it only while no request is pending.
module led_strip_pixel_buffer #(
	parameter int unsigned MAX_PIXELS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [lspb_pkg::ACTION_W-1:0]       action,
	input  logic [lspb_pkg::INDEX_W-1:0]        pixel_index,
	input  logic [lspb_pkg::CHAN_W-1:0]         red,
	input  logic [lspb_pkg::CHAN_W-1:0]         green,
	input  logic [lspb_pkg::CHAN_W-1:0]         blue,
	input  logic                                cfg_we,
	input  logic [lspb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lspb_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                strobe,
	output logic [lspb_pkg::WORD_W-1:0]         grb_word,
	output logic                                last
);

	localparam int unsigned CW = $clog2(MAX_PIXELS + 1);

	typedef logic [CW-1:0] count_t;

	// configuration registers
	lspb_pkg::active_t active_q;
	lspb_pkg::gain_t   gain_q;

	// effective pixel count after clamping to the memory size
	count_t         pixel_count;
	logic           renorm;

	// front to queue to back
	logic           q_full;
	logic           q_push;
	lspb_pkg::cmd_t q_cmd;
	logic           q_pop;
	logic           q_valid;
	lspb_pkg::cmd_t q_head;

	// words read from the pixel memory, before scaling
	lspb_pkg::pix_t pix;

	assign pixel_count = (active_q > lspb_pkg::active_t'(MAX_PIXELS)) ?
		count_t'(MAX_PIXELS) : count_t'(active_q);

	// a count write folds the rotation back into physical order first
	assign renorm = cfg_we && (cfg_index == lspb_pkg::REG_ACTIVE_PIXELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= lspb_pkg::ACTIVE_RESET;
			gain_q   <= lspb_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lspb_pkg::REG_ACTIVE_PIXELS: begin
					active_q <= cfg_data[lspb_pkg::ACTIVE_W-1:0];
				end
				lspb_pkg::REG_BRIGHTNESS_GAIN: begin
					gain_q <= cfg_data[lspb_pkg::GAIN_W-1:0];
				end
				default: begin
					gain_q <= gain_q;
				end
			endcase
		end
	end

	// request decode: drops requests that change nothing
	lspb_front #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_front (
		.start       (start),
		.action      (action),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.pixel_count (pixel_count),
		.q_full      (q_full),
		.busy        (busy),
		.push        (q_push),
		.cmd         (q_cmd)
	);

	// decouples request intake from the executor
	lspb_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// executor: pixel memory, rotation base, fill / send / reorder sequencer
	lspb_back #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_count (pixel_count),
		.renorm      (renorm),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.pix         (pix)
	);

	// brightness scaling and the output register
	lspb_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain     (gain_q),
		.pix      (pix),
		.strobe   (strobe),
		.grb_word (grb_word),
		.last     (last)
	);

endmodule

>>> hw/rtl/lspb_checker.sv
module lspb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [lspb_pkg::ACTION_W-1:0]       action,
	input logic [lspb_pkg::INDEX_W-1:0]        pixel_index,
	input logic [lspb_pkg::CHAN_W-1:0]         red,
	input logic [lspb_pkg::CHAN_W-1:0]         green,
	input logic [lspb_pkg::CHAN_W-1:0]         blue,
	input logic                                cfg_we,
	input logic [lspb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input logic [lspb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input logic                                strobe,
	input logic [lspb_pkg::WORD_W-1:0]         grb_word,
	input logic                                last
);

	logic sent_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_seen_q <= 1'b0;
		end else if (start && !busy && action == lspb_pkg::ACT_SEND) begin
			sent_seen_q <= 1'b1;
		end
	end

	// the queue only fills behind an accepted request
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// no word without a send request before it
	a_word_needs_send: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> sent_seen_q)
		else $error("word emitted before any send request");

	a_last_marks_word: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last high without a word");

	// a frame is emitted without gaps
	a_frame_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a frame");

endmodule

bind led_strip_pixel_buffer lspb_checker u_lspb_checker (.*);

>>> verif/led_strip_pixel_buffer_tb.sv
`timescale 1ns / 1ps

module led_strip_pixel_buffer_tb;

	localparam int unsigned STRIP_MAX     = 64;
	localparam int unsigned SETTLE_CYCLES = 400;
	localparam int unsigned REPORT_LIMIT  = 10;

	typedef logic [lspb_pkg::ACTION_W-1:0]   op_code_t;
	typedef logic [lspb_pkg::CFG_DATA_W-1:0] cfg_data_t;

	// action codes past the last defined one, which the block must ignore
	localparam op_code_t ACT_SPARE_FIRST = 3'd5;
	localparam op_code_t ACT_SPARE_MID   = 3'd6;
	localparam op_code_t ACT_SPARE_LAST  = 3'd7;

	typedef struct packed {
		op_code_t          op;
		lspb_pkg::index_t  idx;
		lspb_pkg::chan_t   r, g, b;
	} strip_cmd_t;

	typedef struct packed {
		lspb_pkg::word_t grb;
		logic            last;
	} frame_word_t;

	// dut ports; the inputs are all known from time zero
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic                  busy;
	op_code_t              action      = '0;
	lspb_pkg::index_t      pixel_index = '0;
	lspb_pkg::chan_t       red         = '0;
	lspb_pkg::chan_t       green       = '0;
	lspb_pkg::chan_t       blue        = '0;
	logic                  cfg_we      = 1'b0;
	lspb_pkg::cfg_index_t  cfg_index   = '0;
	cfg_data_t             cfg_data    = '0;
	logic                  strobe;
	lspb_pkg::word_t       grb_word;
	logic                  last;

	// commands waiting to be requested, and frame words still owed by the block
	strip_cmd_t  cmd_q[$];
	frame_word_t word_q[$];

	// shadow copy of the strip state
	lspb_pkg::word_t   shadow_px [STRIP_MAX];
	int unsigned       shadow_base;
	lspb_pkg::active_t shadow_active;
	lspb_pkg::gain_t   shadow_gain;

	int unsigned mismatch_count;
	int unsigned burst_left;
	int unsigned gap_left;

	led_strip_pixel_buffer #(
		.MAX_PIXELS(STRIP_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.grb_word(grb_word),
		.last(last)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// shadow model of the strip
	// ---------------------------------------------------------------

	// counts above the strip size saturate
	function automatic int unsigned strip_len();
		return (int'(shadow_active) > STRIP_MAX) ? STRIP_MAX : int'(shadow_active);
	endfunction

	// logical pixel to physical entry under the current rotation
	function automatic int unsigned strip_slot(int unsigned logical, int unsigned n);
		return (shadow_base + logical) % n;
	endfunction

	// floor(c * gain / 255)
	function automatic lspb_pkg::chan_t dim_channel(lspb_pkg::chan_t c);
		int unsigned prod;
		prod = int'(c) * int'(shadow_gain);
		return lspb_pkg::chan_t'(prod / 255);
	endfunction

	// update the shadow for one accepted request, queue the words a send owes
	function automatic void strip_command(op_code_t op, lspb_pkg::index_t idx,
		lspb_pkg::chan_t r, lspb_pkg::chan_t g, lspb_pkg::chan_t b);
		int unsigned     n;
		lspb_pkg::word_t px;
		frame_word_t     w;
		n = strip_len();
		// an empty strip ignores every command
		if (n == 0)
			return;
		case (op)
			lspb_pkg::ACT_SET_ONE: begin
				// out-of-range index drops the write
				if (int'(idx) < n)
					shadow_px[strip_slot(idx, n)] = {g, r, b};
			end
			lspb_pkg::ACT_SET_ALL: begin
				for (int unsigned i = 0; i < n; i++)
					shadow_px[i] = {g, r, b};
			end
			lspb_pkg::ACT_ROT_RIGHT: shadow_base = ((shadow_base % n) + n - 1) % n;
			lspb_pkg::ACT_ROT_LEFT:  shadow_base = ((shadow_base % n) + 1) % n;
			lspb_pkg::ACT_SEND: begin
				for (int unsigned i = 0; i < n; i++) begin
					px = shadow_px[strip_slot(i, n)];
					w.grb  = {dim_channel(px[23:16]), dim_channel(px[15:8]),
						dim_channel(px[7:0])};
					w.last = (i + 1 == n);
					word_q.insert(word_q.size(), w);
				end
			end
			default: ;
		endcase
	endfunction

	// a count write first unrolls the rotation into physical order
	function automatic void strip_reg_write(lspb_pkg::cfg_index_t idx, cfg_data_t val);
		lspb_pkg::word_t unrolled [STRIP_MAX];
		int unsigned     n;
		if (idx == lspb_pkg::REG_ACTIVE_PIXELS) begin
			n = strip_len();
			if (n != 0) begin
				for (int unsigned i = 0; i < n; i++)
					unrolled[i] = shadow_px[strip_slot(i, n)];
				for (int unsigned i = 0; i < n; i++)
					shadow_px[i] = unrolled[i];
			end
			shadow_base   = 0;
			shadow_active = val[lspb_pkg::ACTIVE_W-1:0];
		end else begin
			shadow_gain = val;
		end
	endfunction

	// ---------------------------------------------------------------
	// driver: requests in bursts with random gaps
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		strip_cmd_t c;
		if (!arst_n) begin
			start      <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			// request taken this edge: fold it into the shadow from the held ports
			if (start && !busy)
				strip_command(action, pixel_index, red, green, blue);
			// a request held off by busy stays on the ports untouched
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					c = cmd_q.pop_front();
					start       <= 1'b1;
					action      <= c.op;
					pixel_index <= c.idx;
					red         <= c.r;
					green       <= c.g;
					blue        <= c.b;
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(0, 5) == 0) begin
						// long stretch with no idling
						burst_left = 40;
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: every strobe must match the oldest owed word
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		frame_word_t want;
		if (arst_n && strobe) begin
			if (word_q.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("unexpected word grb=%06h last=%0b at %0t",
						grb_word, last, $realtime);
				mismatch_count++;
			end else begin
				want = word_q.pop_front();
				if (want.grb !== grb_word || want.last !== last) begin
					if (mismatch_count < REPORT_LIMIT)
						$display({"word mismatch: expected grb=%06h last=%0b, ",
							"got grb=%06h last=%0b at %0t"},
							want.grb, want.last, grb_word, last, $realtime);
					mismatch_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic add_cmd(op_code_t op, lspb_pkg::index_t idx, lspb_pkg::chan_t r,
		lspb_pkg::chan_t g, lspb_pkg::chan_t b);
		strip_cmd_t c;
		c = '{op: op, idx: idx, r: r, g: g, b: b};
		cmd_q.insert(cmd_q.size(), c);
	endtask

	// channel value biased toward the extremes
	function automatic lspb_pkg::chan_t pick_chan();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return lspb_pkg::chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	// random mix over all actions; indexes mostly land on active pixels
	task automatic add_random(int unsigned count);
		int unsigned      n;
		lspb_pkg::index_t idx;
		int unsigned      pick;
		n = strip_len();
		repeat (count) begin
			idx = lspb_pkg::index_t'($urandom_range(0, 255));
			if (n != 0 && $urandom_range(0, 4) != 0)
				idx = lspb_pkg::index_t'($urandom_range(0, n - 1));
			pick = $urandom_range(0, 99);
			if (pick < 32)
				add_cmd(lspb_pkg::ACT_SET_ONE, idx, pick_chan(), pick_chan(), pick_chan());
			else if (pick < 42)
				add_cmd(lspb_pkg::ACT_SET_ALL, idx, pick_chan(), pick_chan(), pick_chan());
			else if (pick < 57)
				add_cmd(lspb_pkg::ACT_ROT_RIGHT, idx, pick_chan(), pick_chan(), pick_chan());
			else if (pick < 72)
				add_cmd(lspb_pkg::ACT_ROT_LEFT, idx, pick_chan(), pick_chan(), pick_chan());
			else if (pick < 94)
				add_cmd(lspb_pkg::ACT_SEND, idx, pick_chan(), pick_chan(), pick_chan());
			else
				add_cmd(op_code_t'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), idx,
					pick_chan(), pick_chan(), pick_chan());
		end
	endtask

	// let every request and every owed word go through, then let the block settle
	task automatic drain();
		wait (cmd_q.size() == 0);
		@(posedge clk);
		while (start || busy || word_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only ever issued with the block idle
	task automatic write_reg(lspb_pkg::cfg_index_t idx, cfg_data_t val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		strip_reg_write(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		// count / gain pairs per phase: single pixel, over-size count, empty strip,
		// a count with the unused top data bit set, and zero and full gain
		cfg_data_t phase_active [12] = '{8'd1, 8'd64, 8'd100, 8'd0, 8'd2, 8'd127,
			8'd33, 8'h85, 8'd0, 8'd17, 8'd64, 8'd3};
		cfg_data_t phase_gain [12] = '{8'd0, 8'd128, 8'd255, 8'd77, 8'd1, 8'd254,
			8'd200, 8'd255, 8'd9, 8'd3, 8'd170, 8'd255};

		foreach (shadow_px[i])
			shadow_px[i] = '0;
		shadow_base    = 0;
		shadow_active  = lspb_pkg::ACTIVE_RESET;
		shadow_gain    = lspb_pkg::GAIN_RESET;
		mismatch_count = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: store cleared at reset, edge indexes, all actions, extremes
		add_cmd(lspb_pkg::ACT_SEND, 8'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(lspb_pkg::ACT_SET_ONE, 8'd0, 8'hff, 8'hff, 8'hff);
		add_cmd(lspb_pkg::ACT_SET_ONE, 8'd63, 8'h01, 8'h80, 8'hfe);
		add_cmd(lspb_pkg::ACT_SET_ONE, 8'd64, 8'hff, 8'hff, 8'hff);   // just past the end
		add_cmd(lspb_pkg::ACT_SET_ONE, 8'd255, 8'h55, 8'haa, 8'h0f);  // far past the end
		add_cmd(lspb_pkg::ACT_SEND, 8'hff, 8'hff, 8'hff, 8'hff);
		add_cmd(lspb_pkg::ACT_SET_ALL, 8'd0, 8'hff, 8'h00, 8'hff);
		add_cmd(lspb_pkg::ACT_SET_ONE, 8'd31, 8'ha5, 8'h5a, 8'h3c);
		add_cmd(lspb_pkg::ACT_SET_ONE, 8'd1, 8'h00, 8'hff, 8'h00);
		add_cmd(lspb_pkg::ACT_ROT_RIGHT, 8'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(lspb_pkg::ACT_SEND, 8'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(lspb_pkg::ACT_ROT_LEFT, 8'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(lspb_pkg::ACT_ROT_LEFT, 8'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(lspb_pkg::ACT_SET_ONE, 8'd0, 8'h12, 8'h34, 8'h56);   // lands on a rotated entry
		add_cmd(lspb_pkg::ACT_SEND, 8'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(ACT_SPARE_FIRST, 8'd0, 8'hff, 8'hff, 8'hff);
		add_cmd(ACT_SPARE_MID, 8'd7, 8'h11, 8'h22, 8'h33);
		add_cmd(ACT_SPARE_LAST, 8'd200, 8'h00, 8'hff, 8'h00);
		add_cmd(lspb_pkg::ACT_SET_ALL, 8'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(lspb_pkg::ACT_SET_ONE, 8'd10, 8'hff, 8'hff, 8'hff);
		add_cmd(lspb_pkg::ACT_ROT_RIGHT, 8'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(lspb_pkg::ACT_SEND, 8'd0, 8'h00, 8'h00, 8'h00);
		drain();

		// random phases, each under its own count and gain; the strip is usually
		// left rotated when the count changes, so the unroll gets exercised
		for (int p = 0; p < 12; p++) begin
			write_reg(lspb_pkg::REG_ACTIVE_PIXELS, phase_active[p]);
			write_reg(lspb_pkg::REG_BRIGHTNESS_GAIN, phase_gain[p]);
			add_random((strip_len() == 0) ? 8 : 24);
			add_cmd(lspb_pkg::ACT_SEND, 8'd0, 8'h00, 8'h00, 8'h00);
			add_cmd(lspb_pkg::ACT_ROT_LEFT, 8'd0, 8'h00, 8'h00, 8'h00);
			drain();
		end

		// gain change alone, then one last frame
		write_reg(lspb_pkg::REG_BRIGHTNESS_GAIN, lspb_pkg::gain_t'($urandom_range(0, 255)));
		add_cmd(lspb_pkg::ACT_SEND, 8'd0, 8'h00, 8'h00, 8'h00);
		drain();

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/lspb_pkg.sv
hw/rtl/lspb_front.sv
hw/rtl/lspb_cmd_queue.sv
hw/rtl/lspb_back.sv
hw/rtl/lspb_scale.sv
hw/rtl/led_strip_pixel_buffer.sv
hw/rtl/lspb_checker.sv
verif/led_strip_pixel_buffer_tb.sv
